/* hdl/ccec_pkg.sv */
// Shared types and codes for the coincidence counter with elapsed clock.
`timescale 1ns / 1ps

package ccec_pkg;

  localparam logic [15:0] SEC_MODE_TICKS_DEF = 16'd4000;
  localparam logic [7:0]  MIN_MODE_TICKS_DEF = 8'd125;
  localparam logic [7:0]  MINUTE_WRAP_DEF    = 8'd60;

  localparam logic [2:0] MODE_TICK       = 3'd0;
  localparam logic [2:0] MODE_TUBE_PORT  = 3'd1;
  localparam logic [2:0] MODE_SECOND_PORT = 3'd2;
  localparam logic [2:0] MODE_GM_FLASH   = 3'd3;
  localparam logic [2:0] MODE_MUON_FLASH = 3'd4;
  localparam logic [2:0] MODE_GM_BUZZ    = 3'd5;
  localparam logic [2:0] MODE_MUON_BUZZ  = 3'd6;

  localparam logic [7:0] TMODE_SEC_A = 8'h3F;
  localparam logic [7:0] TMODE_SEC_B = 8'h15;
  localparam logic [7:0] TMODE_MIN_A = 8'h00;
  localparam logic [7:0] TMODE_MIN_B = 8'h40;

  localparam logic [3:0] PAT_AC_BD  = 4'hD;
  localparam logic [3:0] PAT_AD     = 4'hB;
  localparam logic [3:0] PAT_AB_CD  = 4'hE;
  localparam logic [3:0] PAT_SINGLE = 4'h7;
  localparam logic [7:0] PORT2_BC   = 8'h60;

  localparam logic [4:0] HOURS_PER_DAY = 5'd24;

  localparam logic [7:0] W_GM_LED    = 8'd8;
  localparam logic [7:0] W_MUON_LED  = 8'd32;
  localparam logic [7:0] W_GM_BUZZ   = 8'd1;
  localparam logic [7:0] W_MUON_BUZZ = 8'd2;

  localparam logic CFG_TIMER_MODE      = 1'b0;
  localparam logic CFG_INDICATOR_STATE = 1'b1;

  typedef struct packed {
    logic        snapshot_taken;
    logic [15:0] ac_bd_count;
    logic [15:0] ad_count;
    logic [15:0] bc_count;
    logic [15:0] ab_cd_count;
    logic [15:0] all_hits_count;
    logic [7:0]  elapsed_days;
    logic [4:0]  elapsed_hours;
    logic [7:0]  elapsed_minutes;
    logic [7:0]  elapsed_seconds;
  } result_t;

endpackage

/* hdl/coincidence_counter_with_elapsed_clock.sv */
// Top level of the coincidence counter with elapsed clock.
`timescale 1ns / 1ps

// Each input request carries one event: a timer tick, a tube port sample, a
// second port sample, or an indicator flash or buzz. Every accepted request
// yields exactly one result request with the currently published snapshot
// and a flag that tells whether this event took a new snapshot.
// All counter and clock updates happen in the cycle the request is accepted,
// and the result is registered. One request can be accepted every cycle
// while in_stall is low; the counters and the elapsed time are updated
// combinationally, and the compensation split comes from a constant lookup
// table.
// A two-entry output buffer (result register plus skid register) lets the
// block take a new request while a result still waits. When the receiver
// stalls and both entries are full, in_stall is raised until one drains.
// Configuration writes are always ready and should be made while idle.
// Reset clears all counters, the published snapshot, the configuration and
// the output buffer.
module coincidence_counter_with_elapsed_clock
  import ccec_pkg::*;
#(
  parameter logic [15:0] SEC_MODE_TICKS = SEC_MODE_TICKS_DEF,
  parameter logic [7:0]  MIN_MODE_TICKS = MIN_MODE_TICKS_DEF,
  parameter logic [7:0]  MINUTE_WRAP    = MINUTE_WRAP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_pin_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_snapshot_taken,
  output logic [15:0] out_ac_bd_count,
  output logic [15:0] out_ad_count,
  output logic [15:0] out_bc_count,
  output logic [15:0] out_ab_cd_count,
  output logic [15:0] out_all_hits_count,
  output logic [7:0]  out_elapsed_days,
  output logic [4:0]  out_elapsed_hours,
  output logic [7:0]  out_elapsed_minutes,
  output logic [7:0]  out_elapsed_seconds,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  typedef logic [255:0][15:0] split_tab_t;

  function automatic split_tab_t build_split_tab();
    split_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = {8'(i / MIN_MODE_TICKS), 8'(i % MIN_MODE_TICKS)};
    end
    return tab;
  endfunction

  localparam split_tab_t SPLIT_TAB = build_split_tab();

  logic [7:0]  timer_mode_r;
  logic [3:0]  indicator_state_r;
  logic [15:0] tick_r, tick_nxt;
  logic [7:0]  seconds_r, seconds_nxt;
  logic [7:0]  minutes_r, minutes_nxt;
  logic [4:0]  hours_r, hours_nxt;
  logic [7:0]  days_r, days_nxt;
  logic [15:0] ac_bd_r, ac_bd_nxt;
  logic [15:0] ad_r, ad_nxt;
  logic [15:0] bc_r, bc_nxt;
  logic [15:0] ab_cd_r, ab_cd_nxt;
  logic [15:0] total_r, total_nxt;
  logic [7:0]  comp_sum_r, comp_sum_nxt;
  result_t     pub_r, pub_nxt;
  result_t     out_r, skid_r;
  logic        out_valid_r, skid_valid_r;

  logic        push, pop;
  logic [15:0] tick_inc;
  logic [15:0] terminal;
  logic        armed;
  logic        fired;
  logic [15:0] split;
  logic [7:0]  sec_step;
  logic [7:0]  min_step;
  logic [4:0]  hour_step;
  logic [1:0]  led_en;
  logic [1:0]  buz_en;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign push      = in_valid && !skid_valid_r;
  assign pop       = out_valid_r && !out_stall;
  assign led_en    = indicator_state_r[3:2];
  assign buz_en    = indicator_state_r[1:0];
  assign tick_inc  = tick_r + 16'd1;
  assign split     = SPLIT_TAB[comp_sum_r];
  assign sec_step  = seconds_r + 8'd1 + split[15:8];
  assign min_step  = minutes_r + 8'd1;
  assign hour_step = hours_r + 5'd1;

  always_comb begin
    armed    = 1'b0;
    terminal = SEC_MODE_TICKS;
    if (timer_mode_r == TMODE_SEC_A || timer_mode_r == TMODE_SEC_B) begin
      armed = 1'b1;
    end else if (timer_mode_r == TMODE_MIN_A || timer_mode_r == TMODE_MIN_B) begin
      armed    = 1'b1;
      terminal = {8'd0, MIN_MODE_TICKS};
    end
  end

  always_comb begin
    tick_nxt     = tick_r;
    seconds_nxt  = seconds_r;
    minutes_nxt  = minutes_r;
    hours_nxt    = hours_r;
    days_nxt     = days_r;
    ac_bd_nxt    = ac_bd_r;
    ad_nxt       = ad_r;
    bc_nxt       = bc_r;
    ab_cd_nxt    = ab_cd_r;
    total_nxt    = total_r;
    comp_sum_nxt = comp_sum_r;
    pub_nxt      = pub_r;
    fired        = 1'b0;
    case (in_mode)
      MODE_TICK: begin
        tick_nxt = tick_inc;
        if (armed && tick_inc == terminal) begin
          fired                   = 1'b1;
          pub_nxt.ac_bd_count     = ac_bd_r;
          pub_nxt.ad_count        = ad_r;
          pub_nxt.bc_count        = bc_r;
          pub_nxt.ab_cd_count     = ab_cd_r;
          pub_nxt.all_hits_count  = total_r;
          pub_nxt.elapsed_days    = days_r;
          pub_nxt.elapsed_hours   = hours_r;
          pub_nxt.elapsed_minutes = minutes_r;
          pub_nxt.elapsed_seconds = seconds_r;
          tick_nxt     = {8'd0, split[7:0]};
          comp_sum_nxt = 8'd0;
          seconds_nxt  = sec_step;
          if (sec_step == MINUTE_WRAP) begin
            seconds_nxt = 8'd0;
            minutes_nxt = min_step;
            if (min_step == MINUTE_WRAP) begin
              minutes_nxt = 8'd0;
              hours_nxt   = hour_step;
              if (hour_step == HOURS_PER_DAY) begin
                hours_nxt = 5'd0;
                days_nxt  = days_r + 8'd1;
              end
            end
          end
        end
      end
      MODE_TUBE_PORT: begin
        case (in_pin_sample[3:0])
          PAT_AC_BD: begin
            ac_bd_nxt = ac_bd_r + 16'd1;
            total_nxt = total_r + 16'd2;
          end
          PAT_AD: begin
            ad_nxt    = ad_r + 16'd1;
            total_nxt = total_r + 16'd2;
          end
          PAT_AB_CD: begin
            ab_cd_nxt = ab_cd_r + 16'd1;
            total_nxt = total_r + 16'd2;
          end
          PAT_SINGLE: begin
            total_nxt = total_r + 16'd1;
          end
          default: begin
          end
        endcase
      end
      MODE_SECOND_PORT: begin
        if (in_pin_sample == PORT2_BC) begin
          bc_nxt    = bc_r + 16'd1;
          total_nxt = total_r + 16'd2;
        end
      end
      MODE_GM_FLASH: begin
        if (led_en inside {2'd1, 2'd2}) comp_sum_nxt = comp_sum_r + W_GM_LED;
      end
      MODE_MUON_FLASH: begin
        if (led_en inside {2'd1, 2'd2}) comp_sum_nxt = comp_sum_r + W_MUON_LED;
      end
      MODE_GM_BUZZ: begin
        if (buz_en inside {2'd2, 2'd3}) comp_sum_nxt = comp_sum_r + W_GM_BUZZ;
      end
      MODE_MUON_BUZZ: begin
        if (buz_en inside {2'd1, 2'd3}) comp_sum_nxt = comp_sum_r + W_MUON_BUZZ;
      end
      default: begin
      end
    endcase
    pub_nxt.snapshot_taken = fired;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_mode_r      <= 8'd0;
      indicator_state_r <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TIMER_MODE:      timer_mode_r      <= cfg_data;
        CFG_INDICATOR_STATE: indicator_state_r <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r     <= '0;
      seconds_r  <= '0;
      minutes_r  <= '0;
      hours_r    <= '0;
      days_r     <= '0;
      ac_bd_r    <= '0;
      ad_r       <= '0;
      bc_r       <= '0;
      ab_cd_r    <= '0;
      total_r    <= '0;
      comp_sum_r <= '0;
      pub_r      <= '0;
    end else if (push) begin
      tick_r     <= tick_nxt;
      seconds_r  <= seconds_nxt;
      minutes_r  <= minutes_nxt;
      hours_r    <= hours_nxt;
      days_r     <= days_nxt;
      ac_bd_r    <= ac_bd_nxt;
      ad_r       <= ad_nxt;
      bc_r       <= bc_nxt;
      ab_cd_r    <= ab_cd_nxt;
      total_r    <= total_nxt;
      comp_sum_r <= comp_sum_nxt;
      pub_r      <= pub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_r       <= pub_nxt;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= pub_nxt;
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_snapshot_taken  = out_r.snapshot_taken;
  assign out_ac_bd_count     = out_r.ac_bd_count;
  assign out_ad_count        = out_r.ad_count;
  assign out_bc_count        = out_r.bc_count;
  assign out_ab_cd_count     = out_r.ab_cd_count;
  assign out_all_hits_count  = out_r.all_hits_count;
  assign out_elapsed_days    = out_r.elapsed_days;
  assign out_elapsed_hours   = out_r.elapsed_hours;
  assign out_elapsed_minutes = out_r.elapsed_minutes;
  assign out_elapsed_seconds = out_r.elapsed_seconds;

endmodule

/* tb/tb_coincidence_counter_with_elapsed_clock.sv */
// Self-checking testbench for the coincidence counter with elapsed clock.
`timescale 1ns / 1ps

module tb_coincidence_counter_with_elapsed_clock;
  import ccec_pkg::*;

  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam logic [7:0] TMODE_NONE  = 8'hFF;

  localparam int IX_AC_BD     = 0;
  localparam int IX_AD        = 1;
  localparam int IX_BC        = 2;
  localparam int IX_AB_CD     = 3;
  localparam int IX_TOTAL     = 4;
  localparam int IX_GM_LED    = 0;
  localparam int IX_MUON_LED  = 1;
  localparam int IX_GM_BUZZ   = 2;
  localparam int IX_MUON_BUZZ = 3;

  class snapshot_predictor;
    logic [15:0] tick_cnt;
    logic [7:0]  secs;
    logic [7:0]  mins;
    logic [4:0]  hrs;
    logic [7:0]  day_cnt;
    logic [15:0] hits [5];
    logic [7:0]  flash_buzz [4];
    result_t     published;
    logic [7:0]  timer_mode;
    logic [3:0]  indicator;
    result_t     expected_snapshots [$];
    int          errors;

    function new();
      tick_cnt = '0;
      secs = '0;
      mins = '0;
      hrs = '0;
      day_cnt = '0;
      foreach (hits[i]) hits[i] = '0;
      foreach (flash_buzz[i]) flash_buzz[i] = '0;
      published = '0;
      timer_mode = '0;
      indicator = '0;
      errors = 0;
    endfunction

    function void set_register(logic idx, logic [7:0] value);
      if (idx == CFG_TIMER_MODE) timer_mode = value;
      else indicator = value[3:0];
    endfunction

    function bit armed();
      return timer_mode == TMODE_SEC_A || timer_mode == TMODE_SEC_B ||
             timer_mode == TMODE_MIN_A || timer_mode == TMODE_MIN_B;
    endfunction

    function logic [15:0] terminal_ticks();
      if (timer_mode == TMODE_SEC_A || timer_mode == TMODE_SEC_B) return SEC_MODE_TICKS_DEF;
      return {8'd0, MIN_MODE_TICKS_DEF};
    endfunction

    function int ticks_to_terminal();
      logic [15:0] left;
      if (!armed()) return 0;
      left = terminal_ticks() - tick_cnt;
      return (left == 16'd0) ? 65536 : int'(left);
    endfunction

    // The snapshot shows the time before this second is counted. Indicator
    // time is folded back in as whole seconds plus leftover ticks.
    function void take_snapshot();
      logic [7:0] lost;
      published.elapsed_days    = day_cnt;
      published.elapsed_hours   = hrs;
      published.elapsed_minutes = mins;
      published.elapsed_seconds = secs;
      published.ac_bd_count     = hits[IX_AC_BD];
      published.ad_count        = hits[IX_AD];
      published.bc_count        = hits[IX_BC];
      published.ab_cd_count     = hits[IX_AB_CD];
      published.all_hits_count  = hits[IX_TOTAL];
      lost = flash_buzz[IX_GM_LED] * W_GM_LED + flash_buzz[IX_GM_BUZZ] * W_GM_BUZZ +
             flash_buzz[IX_MUON_LED] * W_MUON_LED + flash_buzz[IX_MUON_BUZZ] * W_MUON_BUZZ;
      secs = secs + 8'd1 + lost / MIN_MODE_TICKS_DEF;
      tick_cnt = {8'd0, lost % MIN_MODE_TICKS_DEF};
      foreach (flash_buzz[i]) flash_buzz[i] = '0;
      if (secs == MINUTE_WRAP_DEF) begin
        secs = '0;
        mins = mins + 8'd1;
        if (mins == MINUTE_WRAP_DEF) begin
          mins = '0;
          hrs = hrs + 5'd1;
          if (hrs == HOURS_PER_DAY) begin
            hrs = '0;
            day_cnt = day_cnt + 8'd1;
          end
        end
      end
    endfunction

    function void accept_event(logic [2:0] mode, logic [7:0] pin);
      result_t want;
      logic    fired;
      logic    led_on;
      fired = 1'b0;
      led_on = indicator[3] ^ indicator[2];
      case (mode)
        MODE_TICK: begin
          tick_cnt = tick_cnt + 16'd1;
          if (armed() && tick_cnt == terminal_ticks()) begin
            take_snapshot();
            fired = 1'b1;
          end
        end
        MODE_TUBE_PORT: begin
          case (pin[3:0])
            PAT_AC_BD: begin
              hits[IX_AC_BD] = hits[IX_AC_BD] + 16'd1;
              hits[IX_TOTAL] = hits[IX_TOTAL] + 16'd2;
            end
            PAT_AD: begin
              hits[IX_AD] = hits[IX_AD] + 16'd1;
              hits[IX_TOTAL] = hits[IX_TOTAL] + 16'd2;
            end
            PAT_AB_CD: begin
              hits[IX_AB_CD] = hits[IX_AB_CD] + 16'd1;
              hits[IX_TOTAL] = hits[IX_TOTAL] + 16'd2;
            end
            PAT_SINGLE: hits[IX_TOTAL] = hits[IX_TOTAL] + 16'd1;
            default: ;
          endcase
        end
        MODE_SECOND_PORT: begin
          if (pin == PORT2_BC) begin
            hits[IX_BC] = hits[IX_BC] + 16'd1;
            hits[IX_TOTAL] = hits[IX_TOTAL] + 16'd2;
          end
        end
        MODE_GM_FLASH: begin
          if (led_on) flash_buzz[IX_GM_LED] = flash_buzz[IX_GM_LED] + 8'd1;
        end
        MODE_MUON_FLASH: begin
          if (led_on) flash_buzz[IX_MUON_LED] = flash_buzz[IX_MUON_LED] + 8'd1;
        end
        MODE_GM_BUZZ: begin
          if (indicator[1]) flash_buzz[IX_GM_BUZZ] = flash_buzz[IX_GM_BUZZ] + 8'd1;
        end
        MODE_MUON_BUZZ: begin
          if (indicator[0]) flash_buzz[IX_MUON_BUZZ] = flash_buzz[IX_MUON_BUZZ] + 8'd1;
        end
        default: ;
      endcase
      want = published;
      want.snapshot_taken = fired;
      expected_snapshots.push_back(want);
    endfunction

    function void compare_field(string what, logic [15:0] want_v, logic [15:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: %s expected %0h got %0h", $time, what, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_snapshot(result_t got);
      result_t want;
      if (expected_snapshots.size() == 0) begin
        $display("%0t: result with no request waiting", $time);
        errors++;
        return;
      end
      want = expected_snapshots.pop_front();
      compare_field("snapshot_taken", 16'(want.snapshot_taken), 16'(got.snapshot_taken));
      compare_field("ac_bd_count", want.ac_bd_count, got.ac_bd_count);
      compare_field("ad_count", want.ad_count, got.ad_count);
      compare_field("bc_count", want.bc_count, got.bc_count);
      compare_field("ab_cd_count", want.ab_cd_count, got.ab_cd_count);
      compare_field("all_hits_count", want.all_hits_count, got.all_hits_count);
      compare_field("elapsed_days", 16'(want.elapsed_days), 16'(got.elapsed_days));
      compare_field("elapsed_hours", 16'(want.elapsed_hours), 16'(got.elapsed_hours));
      compare_field("elapsed_minutes", 16'(want.elapsed_minutes),
                    16'(got.elapsed_minutes));
      compare_field("elapsed_seconds", 16'(want.elapsed_seconds),
                    16'(got.elapsed_seconds));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_mode = '0;
  logic [7:0]  in_pin_sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_snapshot_taken;
  logic [15:0] out_ac_bd_count;
  logic [15:0] out_ad_count;
  logic [15:0] out_bc_count;
  logic [15:0] out_ab_cd_count;
  logic [15:0] out_all_hits_count;
  logic [7:0]  out_elapsed_days;
  logic [4:0]  out_elapsed_hours;
  logic [7:0]  out_elapsed_minutes;
  logic [7:0]  out_elapsed_seconds;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;

  snapshot_predictor pred = new();
  result_t           seen;
  int                burst_left = 0;
  int                sent = 0;

  coincidence_counter_with_elapsed_clock dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_pin_sample      (in_pin_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_snapshot_taken (out_snapshot_taken),
    .out_ac_bd_count    (out_ac_bd_count),
    .out_ad_count       (out_ad_count),
    .out_bc_count       (out_bc_count),
    .out_ab_cd_count    (out_ab_cd_count),
    .out_all_hits_count (out_all_hits_count),
    .out_elapsed_days   (out_elapsed_days),
    .out_elapsed_hours  (out_elapsed_hours),
    .out_elapsed_minutes(out_elapsed_minutes),
    .out_elapsed_seconds(out_elapsed_seconds),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen = {out_snapshot_taken, out_ac_bd_count, out_ad_count, out_bc_count,
                out_ab_cd_count, out_all_hits_count, out_elapsed_days, out_elapsed_hours,
                out_elapsed_minutes, out_elapsed_seconds};
        pred.check_snapshot(seen);
      end
      if (in_valid && !in_stall) pred.accept_event(in_mode, in_pin_sample);
      if (cfg_valid && cfg_ready) pred.set_register(cfg_index, cfg_data);
    end
  end

  task automatic send_event(input logic [2:0] m, input logic [7:0] p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_mode <= m;
    in_pin_sample <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_hit();
    logic [7:0] p;
    p = 8'($urandom);
    case ($urandom_range(5))
      0: p[3:0] = PAT_AC_BD;
      1: p[3:0] = PAT_AD;
      2: p[3:0] = PAT_AB_CD;
      3: p[3:0] = PAT_SINGLE;
      default: ;
    endcase
    if ($urandom_range(3) == 0) send_event(MODE_SECOND_PORT, $urandom_range(1) ? PORT2_BC : p);
    else send_event(MODE_TUBE_PORT, p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pred.expected_snapshots.size() != 0) @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] tmode, input logic [3:0] ind);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TIMER_MODE;
    cfg_data <= tmode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= CFG_INDICATOR_STATE;
    cfg_data <= {4'd0, ind};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_sequences(input int count);
    int stop_at;
    int kind;
    int need;
    stop_at = sent + count;
    while (sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        send_event(3'($urandom), 8'($urandom));
      end else begin
        if (kind < 65) begin
          // Enough indicator time to push the compensation to one or two seconds.
          repeat (7) send_event(MODE_MUON_FLASH, 8'($urandom));
          repeat (3) send_event(MODE_GM_FLASH, 8'($urandom));
          repeat ($urandom_range(7)) send_event(MODE_GM_BUZZ, 8'($urandom));
          repeat ($urandom_range(3)) send_event(MODE_MUON_BUZZ, 8'($urandom));
        end else begin
          repeat ($urandom_range(6)) begin
            if ($urandom_range(1)) send_hit();
            else send_event(3'($urandom_range(MODE_GM_FLASH, MODE_MUON_BUZZ)),
                            8'($urandom));
          end
        end
        need = pred.ticks_to_terminal();
        if (need == 0 || need > 200) need = $urandom_range(1, 12);
        else if ($urandom_range(4) == 0) need = $urandom_range(need - 1);
        repeat (need) send_event(MODE_TICK, 8'($urandom));
      end
    end
  endtask

  initial begin : receiver
    int cycle_no;
    int stretch;
    int stall_pct;
    int hold_left;
    cycle_no = 0;
    stretch = 0;
    stall_pct = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      cycle_no++;
      if (cycle_no % 2000 == 700) hold_left = $urandom_range(40, 90);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (stretch == 0) begin
          stretch = $urandom_range(20, 200);
          case ($urandom_range(3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        stretch--;
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin : stimulus
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Flashes count, gm buzz counts, muon buzz is ignored.
    set_config(TMODE_MIN_A, 4'h6);
    send_event(MODE_TUBE_PORT, {4'h0, PAT_AC_BD});
    send_event(MODE_TUBE_PORT, {4'h0, PAT_AD});
    send_event(MODE_TUBE_PORT, {4'h0, PAT_AB_CD});
    send_event(MODE_TUBE_PORT, {4'h0, PAT_SINGLE});
    send_event(MODE_TUBE_PORT, 8'h00);
    send_event(MODE_TUBE_PORT, {4'hF, PAT_AC_BD});
    send_event(MODE_TUBE_PORT, {4'hF, PAT_SINGLE});
    send_event(MODE_TUBE_PORT, 8'hFF);
    send_event(MODE_SECOND_PORT, PORT2_BC);
    send_event(MODE_SECOND_PORT, PORT2_BC | 8'h01);
    send_event(MODE_SECOND_PORT, PORT2_BC | 8'h80);
    send_event(MODE_SECOND_PORT, 8'hFF);
    send_event(MODE_SECOND_PORT, 8'h00);
    send_event(MODE_GM_FLASH, 8'h00);
    send_event(MODE_MUON_FLASH, 8'hFF);
    send_event(MODE_GM_BUZZ, 8'h00);
    send_event(MODE_MUON_BUZZ, 8'hFF);
    send_event(MODE_UNUSED, 8'hFF);
    send_event(MODE_TICK, 8'hFF);
    send_event(MODE_TICK, 8'h00);

    set_config(TMODE_MIN_A, 4'h7);
    run_sequences(350);
    set_config(TMODE_MIN_B, 4'h5);
    run_sequences(300);
    set_config(TMODE_MIN_A, 4'hA);
    run_sequences(300);
    set_config(TMODE_NONE, 4'hF);
    run_sequences(150);
    set_config(TMODE_SEC_A, 4'h0);
    run_sequences(50);
    set_config(TMODE_SEC_B, 4'h9);
    run_sequences(30);

    set_config(TMODE_MIN_B, 4'($urandom));
    run_sequences(200);

    drain();
    repeat (8) @(posedge clk);
    if (pred.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
